// ----- rtl/core/bc3_block_decoder_macros.svh -----
// Assertion helpers for the BC3 block decoder.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef BC3_BLOCK_DECODER_MACROS_SVH
`define BC3_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication.
`define BC3_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bc3 block decoder assertion failed");

// Next-cycle implication.
`define BC3_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bc3 block decoder assertion failed");

`endif

// ----- rtl/core/bc3_pkg.sv -----
package bc3_pkg;

    localparam logic REG_MIP_WIDTH  = 1'b0;
    localparam logic REG_MIP_HEIGHT = 1'b1;

    localparam int RECIP_31 = 135301;
    localparam int RECIP_63 = 66577;
    localparam int RECIP_3  = 21846;
    localparam int RECIP_7  = 9363;
    localparam int RECIP_5  = 13108;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [7:0][7:0]      apal_t;
    typedef logic [3:0][2:0][7:0] cpal_t;

    typedef struct packed {
        logic [13:0] texel_x;
        logic [13:0] texel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } texel_t;

    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] n;
        logic [30:0] p;
        n = {c, 8'd0} - {8'd0, c};
        p = {18'd0, n} * 31'(RECIP_31);
        return p[29:22];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [13:0] n;
        logic [30:0] p;
        n = {c, 8'd0} - {8'd0, c};
        p = {17'd0, n} * 31'(RECIP_63);
        return p[29:22];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [25:0] p;
        p = {16'd0, n} * 26'(RECIP_3);
        return p[23:16];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [25:0] p;
        p = {15'd0, n} * 26'(RECIP_7);
        return p[23:16];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [25:0] p;
        p = {15'd0, n} * 26'(RECIP_5);
        return p[23:16];
    endfunction

endpackage

// ----- rtl/core/bc3_palette.sv -----
module bc3_palette
    import bc3_pkg::*;
(
    input  logic        aclk,
    input  logic        load_en,
    input  logic [15:0] alpha_ep,
    input  logic [31:0] color_ep,
    output apal_t       apal,
    output cpal_t       cpal
);

    // First half: endpoint expansion and alpha weighted sums.
    logic [7:0]             a0;
    logic [7:0]             a1;
    logic [2:0][7:0]        c0e;
    logic [2:0][7:0]        c1e;
    logic [5:0][10:0]       n7;
    logic [3:0][10:0]       n5;

    logic [7:0]             a0_reg;
    logic [7:0]             a1_reg;
    logic                   mode7_reg;
    logic [2:0][7:0]        c0e_reg;
    logic [2:0][7:0]        c1e_reg;
    logic [5:0][10:0]       n7_reg;
    logic [3:0][10:0]       n5_reg;

    assign a0 = alpha_ep[7:0];
    assign a1 = alpha_ep[15:8];

    always_comb begin
        c0e[0] = expand5(color_ep[15:11]);
        c0e[1] = expand6(color_ep[10:5]);
        c0e[2] = expand5(color_ep[4:0]);
        c1e[0] = expand5(color_ep[31:27]);
        c1e[1] = expand6(color_ep[26:21]);
        c1e[2] = expand5(color_ep[20:16]);
        for (int k = 0; k < 6; k++) begin
            n7[k] = 11'(11'(6 - k) * {3'd0, a0} + 11'(k + 1) * {3'd0, a1});
        end
        for (int k = 0; k < 4; k++) begin
            n5[k] = 11'(11'(4 - k) * {3'd0, a0} + 11'(k + 1) * {3'd0, a1});
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            a0_reg    <= a0;
            a1_reg    <= a1;
            mode7_reg <= (a0 > a1);
            c0e_reg   <= c0e;
            c1e_reg   <= c1e;
            n7_reg    <= n7;
            n5_reg    <= n5;
        end
    end

    // Second half: reciprocal divisions and palette assembly.
    always_comb begin
        apal[0] = a0_reg;
        apal[1] = a1_reg;
        if (mode7_reg) begin
            for (int k = 0; k < 6; k++) begin
                apal[k + 2] = div7(n7_reg[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                apal[k + 2] = div5(n5_reg[k]);
            end
            apal[6] = 8'd0;
            apal[7] = ALPHA_OPAQUE;
        end
        cpal[0] = c0e_reg;
        cpal[1] = c1e_reg;
        for (int ch = 0; ch < 3; ch++) begin
            cpal[2][ch] = div3({1'b0, c0e_reg[ch], 1'b0} + {2'd0, c1e_reg[ch]});
            cpal[3][ch] = div3({2'd0, c0e_reg[ch]} + {1'b0, c1e_reg[ch], 1'b0});
        end
    end

endmodule

// ----- rtl/core/bc3_block_decoder.sv -----
// BC3 (DXT5) block decoder.
// The input channel (s_valid/s_ready) takes one 16-byte block with its block column
// and row. The result channel (m_valid/m_ready) gives one RGBA texel per transfer, in
// raster order within the block, only for texels inside the mip rectangle set by
// mip_width and mip_height; m_last_texel marks the final texel of a block. A block
// that lies wholly outside the mip produces no transfer.
// The configuration port writes mip_width (index 0) or mip_height (index 1) on any
// cycle with cfg_wr_en high; the user must write it only while the decoder is idle,
// which the decoder itself does not enforce. A block passes an input register, a
// palette register, a block register and a texel register to the result channel.
// The texel register emits one texel per cycle while the receiver takes them, so a
// block lasts for as many texels as it has inside the mip, sixteen for an interior
// block. The next blocks are taken in while earlier ones are still emitting.
// Reset clears all valid state and sets both mip dimensions to one. When the receiver
// stalls, the output texel holds and the stages behind it fill and then stall.
`include "bc3_block_decoder_macros.svh"

module bc3_block_decoder
    import bc3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_idx,
    input  logic [14:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_block_col,
    input  logic [11:0] s_block_row,
    input  logic [63:0] s_alpha_word,
    input  logic [63:0] s_color_word,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_texel_x,
    output logic [13:0] m_texel_y,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha_out,
    output logic        m_last_texel
);

    logic [14:0]      mip_width_reg;
    logic [14:0]      mip_height_reg;

    logic             a_valid_reg;
    logic             a_valid_next;
    logic [11:0]      a_bcol_reg;
    logic [11:0]      a_brow_reg;
    logic [63:0]      a_alpha_reg;
    logic [63:0]      a_color_reg;
    logic [15:0]      a_mask;

    logic             p_valid_reg;
    logic             p_valid_next;
    logic [11:0]      p_bcol_reg;
    logic [11:0]      p_brow_reg;
    logic [15:0]      p_mask_reg;
    logic [15:0][2:0] p_aidx_reg;
    logic [15:0][1:0] p_cidx_reg;
    apal_t            p_apal;
    cpal_t            p_cpal;

    logic [15:0]      b_mask_reg;
    logic [15:0]      b_mask_next;
    logic [11:0]      b_bcol_reg;
    logic [11:0]      b_brow_reg;
    logic [15:0][2:0] b_aidx_reg;
    logic [15:0][1:0] b_cidx_reg;
    apal_t            b_apal_reg;
    cpal_t            b_cpal_reg;

    logic             m_valid_reg;
    logic             m_valid_next;
    texel_t           texel_reg;
    texel_t           texel_next;

    logic             s_accept;
    logic             a_move;
    logic             p_move;
    logic             b_valid;
    logic             b_free;
    logic             b_finish;
    logic             out_free;
    logic             emit;
    logic [15:0]      low_bit;
    logic [15:0]      mask_rest;
    logic [3:0]       sel;
    logic [2:0]       sel_ai;
    logic [1:0]       sel_ci;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mip_width_reg  <= 15'd1;
            mip_height_reg <= 15'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx)
                REG_MIP_WIDTH:  mip_width_reg  <= cfg_wr_data;
                REG_MIP_HEIGHT: mip_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Flow control through the stages.
    assign b_valid   = (b_mask_reg != 16'd0);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = b_valid && out_free;
    assign low_bit   = b_mask_reg & (~b_mask_reg + 16'd1);
    assign mask_rest = b_mask_reg & ~low_bit;
    assign b_finish  = emit && (mask_rest == 16'd0);
    assign b_free    = !b_valid || b_finish;
    assign p_move    = p_valid_reg && b_free;
    assign a_move    = a_valid_reg && (!p_valid_reg || p_move);
    assign s_ready   = !a_valid_reg || a_move;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
        p_valid_next = p_valid_reg;
        if (a_move) begin
            p_valid_next = 1'b1;
        end else if (p_move) begin
            p_valid_next = 1'b0;
        end
        b_mask_next = b_mask_reg;
        if (emit) begin
            b_mask_next = mask_rest;
        end
        if (p_move) begin
            b_mask_next = p_mask_reg;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            b_mask_reg  <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            p_valid_reg <= p_valid_next;
            b_mask_reg  <= b_mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Input stage and the texels of the block that fall inside the mip.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_bcol_reg  <= s_block_col;
            a_brow_reg  <= s_block_row;
            a_alpha_reg <= s_alpha_word;
            a_color_reg <= s_color_word;
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            a_mask[i] = ({1'b0, a_bcol_reg, 2'(i)} < mip_width_reg) &&
                        ({1'b0, a_brow_reg, 2'(i >> 2)} < mip_height_reg);
        end
    end

    bc3_palette u_palette (
        .aclk     (aclk),
        .load_en  (a_move),
        .alpha_ep (a_alpha_reg[15:0]),
        .color_ep (a_color_reg[31:0]),
        .apal     (p_apal),
        .cpal     (p_cpal)
    );

    always_ff @(posedge aclk) begin
        if (a_move) begin
            p_bcol_reg <= a_bcol_reg;
            p_brow_reg <= a_brow_reg;
            p_mask_reg <= a_mask;
            p_aidx_reg <= a_alpha_reg[63:16];
            p_cidx_reg <= a_color_reg[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move) begin
            b_bcol_reg <= p_bcol_reg;
            b_brow_reg <= p_brow_reg;
            b_aidx_reg <= p_aidx_reg;
            b_cidx_reg <= p_cidx_reg;
            b_apal_reg <= p_apal;
            b_cpal_reg <= p_cpal;
        end
    end

    // Texel selection: the lowest remaining inside texel goes out next.
    always_comb begin
        sel = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (low_bit[i]) begin
                sel = sel | 4'(i);
            end
        end
        sel_ai = b_aidx_reg[sel];
        sel_ci = b_cidx_reg[sel];
        texel_next.texel_x = {b_bcol_reg, sel[1:0]};
        texel_next.texel_y = {b_brow_reg, sel[3:2]};
        texel_next.red     = b_cpal_reg[sel_ci][0];
        texel_next.green   = b_cpal_reg[sel_ci][1];
        texel_next.blue    = b_cpal_reg[sel_ci][2];
        texel_next.alpha   = b_apal_reg[sel_ai];
        texel_next.last    = (mask_rest == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            texel_reg <= texel_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_texel_x    = texel_reg.texel_x;
    assign m_texel_y    = texel_reg.texel_y;
    assign m_red        = texel_reg.red;
    assign m_green      = texel_reg.green;
    assign m_blue       = texel_reg.blue;
    assign m_alpha_out  = texel_reg.alpha;
    assign m_last_texel = texel_reg.last;

    `BC3_ASSERT_NEXT(a_stage_holds, a_valid_reg && !a_move, a_valid_reg && $stable(a_alpha_reg))
    `BC3_ASSERT_NEXT(emit_marks_last, emit,
        m_valid_reg && (m_last_texel == ($past(mask_rest) == 16'd0)))
    `BC3_ASSERT_NEXT(mask_drops_one, emit && !p_move,
        $countones(b_mask_reg) == $countones($past(b_mask_reg)) - 1)
    `BC3_ASSERT_IMPL(ready_when_empty, !a_valid_reg, s_ready)

endmodule

// ----- dv/bc3_block_decoder_checker.sv -----
`timescale 1ns / 100ps

module bc3_block_decoder_checker
    import bc3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_idx,
    input  logic [14:0] cfg_wr_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [11:0] s_block_col,
    input  logic [11:0] s_block_row,
    input  logic [63:0] s_alpha_word,
    input  logic [63:0] s_color_word,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [13:0] m_texel_x,
    input  logic [13:0] m_texel_y,
    input  logic [7:0]  m_red,
    input  logic [7:0]  m_green,
    input  logic [7:0]  m_blue,
    input  logic [7:0]  m_alpha_out,
    input  logic        m_last_texel,

    output int          error_count,
    output int          texels_pending
);

    texel_t pending_texels[$];
    texel_t oldest;
    int     mip_w;
    int     mip_h;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [13:0] got,
                               input logic [13:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0d expected %0d at texel (%0d,%0d)",
                             name, got, want, oldest.texel_x, oldest.texel_y));
        end
    endtask

    function automatic logic [7:0] expand_channel(input int code, input int full);
        return 8'(code * 255 / full);
    endfunction

    function automatic void decode_block(input logic [11:0] col, input logic [11:0] row,
                                         input logic [63:0] aw, input logic [63:0] cw);
        logic [7:0] alpha_pal [8];
        logic [7:0] color_pal [4][3];
        texel_t     found[$];
        texel_t     t;
        int         a0;
        int         a1;
        int         k;
        int         x;
        int         y;
        int         ci;
        int         ai;

        a0 = int'(aw[7:0]);
        a1 = int'(aw[15:8]);
        alpha_pal[0] = 8'(a0);
        alpha_pal[1] = 8'(a1);
        if (a0 > a1) begin
            for (k = 1; k <= 6; k++) begin
                alpha_pal[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
            end
        end else begin
            for (k = 1; k <= 4; k++) begin
                alpha_pal[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
            end
            alpha_pal[6] = 8'd0;
            alpha_pal[7] = 8'd255;
        end

        for (k = 0; k < 2; k++) begin
            color_pal[k][0] = expand_channel(int'(cw[16 * k + 11 +: 5]), 31);
            color_pal[k][1] = expand_channel(int'(cw[16 * k + 5 +: 6]), 63);
            color_pal[k][2] = expand_channel(int'(cw[16 * k +: 5]), 31);
        end
        for (k = 0; k < 3; k++) begin
            color_pal[2][k] = 8'((2 * int'(color_pal[0][k]) + int'(color_pal[1][k])) / 3);
            color_pal[3][k] = 8'((int'(color_pal[0][k]) + 2 * int'(color_pal[1][k])) / 3);
        end

        for (k = 0; k < 16; k++) begin
            x = 4 * int'(col) + k % 4;
            y = 4 * int'(row) + k / 4;
            if (x < mip_w && y < mip_h) begin
                ci = int'(cw[32 + 2 * k +: 2]);
                ai = int'(aw[16 + 3 * k +: 3]);
                t.texel_x = 14'(x);
                t.texel_y = 14'(y);
                t.red     = color_pal[ci][0];
                t.green   = color_pal[ci][1];
                t.blue    = color_pal[ci][2];
                t.alpha   = alpha_pal[ai];
                t.last    = 1'b0;
                found = {found, t};
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        pending_texels = {pending_texels, found};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mip_w = 1;
            mip_h = 1;
            pending_texels.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_idx == REG_MIP_WIDTH) begin
                    mip_w = int'(cfg_wr_data);
                end else begin
                    mip_h = int'(cfg_wr_data);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_texels.size() == 0) begin
                    report($sformatf("texel (%0d,%0d) with none expected",
                                     m_texel_x, m_texel_y));
                end else begin
                    oldest = pending_texels.pop_front();
                    check_field("texel_x", m_texel_x, oldest.texel_x);
                    check_field("texel_y", m_texel_y, oldest.texel_y);
                    check_field("red", 14'(m_red), 14'(oldest.red));
                    check_field("green", 14'(m_green), 14'(oldest.green));
                    check_field("blue", 14'(m_blue), 14'(oldest.blue));
                    check_field("alpha_out", 14'(m_alpha_out), 14'(oldest.alpha));
                    check_field("last_texel", 14'(m_last_texel), 14'(oldest.last));
                end
            end
            if (s_valid && s_ready) begin
                decode_block(s_block_col, s_block_row, s_alpha_word, s_color_word);
            end
        end
        texels_pending = pending_texels.size();
    end

endmodule

// ----- dv/tb_bc3_block_decoder.sv -----
`timescale 1ns / 100ps

module tb_bc3_block_decoder;
    import bc3_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic        cfg_idx = REG_MIP_WIDTH;
    logic [14:0] cfg_wr_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_block_col = '0;
    logic [11:0] s_block_row = '0;
    logic [63:0] s_alpha_word = '0;
    logic [63:0] s_color_word = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_texel_x;
    logic [13:0] m_texel_y;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha_out;
    logic        m_last_texel;

    int          error_count;
    int          texels_pending;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          texel_taken = 1'b0;
    int          ready_hold = 0;

    always #2 aclk = ~aclk;

    bc3_block_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_idx      (cfg_idx),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_block_col  (s_block_col),
        .s_block_row  (s_block_row),
        .s_alpha_word (s_alpha_word),
        .s_color_word (s_color_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_texel_x    (m_texel_x),
        .m_texel_y    (m_texel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha_out  (m_alpha_out),
        .m_last_texel (m_last_texel)
    );

    bc3_block_decoder_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_idx        (cfg_idx),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_block_col    (s_block_col),
        .s_block_row    (s_block_row),
        .s_alpha_word   (s_alpha_word),
        .s_color_word   (s_color_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_texel_x      (m_texel_x),
        .m_texel_y      (m_texel_y),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha_out    (m_alpha_out),
        .m_last_texel   (m_last_texel),
        .error_count    (error_count),
        .texels_pending (texels_pending)
    );

    // After every texel transfer the receiver draws how long to hold ready low, if receiver_idles is set.
    always @(posedge aclk) begin
        texel_taken <= m_valid && m_ready;
    end

    always @(negedge aclk) begin
        if (texel_taken) begin
            ready_hold = receiver_idles ? $urandom_range(0, 9) : 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end
        m_ready <= aresetn && ready_hold == 0;
    end

    task automatic send_block(input logic [11:0] col, input logic [11:0] row,
                              input logic [63:0] aw, input logic [63:0] cw);
        int gap;

        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_block_col  <= col;
        s_block_row  <= row;
        s_alpha_word <= aw;
        s_color_word <= cw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (texels_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_mip(input logic [14:0] w, input logic [14:0] h);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_idx     <= REG_MIP_WIDTH;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_idx     <= REG_MIP_HEIGHT;
        cfg_wr_data <= h;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int          w;
        int          h;
        int          phase;
        int          n;
        logic [11:0] col;
        logic [11:0] row;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The reset mip is a single texel.
        send_block(12'd0, 12'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_block(12'd1, 12'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_block(12'd0, 12'd1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

        set_mip(15'd16384, 15'd16384);
        send_block(12'hFFF, 12'hFFF, '1, '1);
        send_block(12'd0, 12'd0, '0, '0);
        send_block(12'd7, 12'd3, {48'hFAC688FAC688, 8'h10, 8'hF0}, '0);
        send_block(12'd8, 12'd9, {48'hFAC688FAC688, 8'hF0, 8'h10}, '1);
        send_block(12'd1, 12'd2, {48'hFAC688FAC688, 8'hFF, 8'h00},
                   {32'hE4E4E4E4, 16'h07E0, 16'hF800});
        send_block(12'd2, 12'd1, {48'hFAC688FAC688, 8'h00, 8'hFF},
                   {32'hE4E4E4E4, 16'hFFFF, 16'h001F});
        send_block(12'hAAA, 12'h555, {48'hFAC688FAC688, 8'h80, 8'h80},
                   {32'h1B1B1B1B, 16'h0000, 16'hFFFF});

        set_mip(15'd16383, 15'd16383);
        send_block(12'hFFF, 12'hFFF, {48'hFAC688FAC688, 8'h22, 8'hDD},
                   {32'hE4E4E4E4, 16'h8410, 16'h7BEF});
        send_block(12'h555, 12'hAAA, {48'hFAC688FAC688, 8'hDD, 8'h22},
                   {32'h1B1B1B1B, 16'hF81F, 16'h07FF});

        set_mip(15'd6, 15'd7);
        send_block(12'd1, 12'd1, {48'hFAC688FAC688, 8'h30, 8'hC0},
                   {32'hE4E4E4E4, 16'h001F, 16'hF800});
        send_block(12'd0, 12'd0, {48'hFAC688FAC688, 8'hC0, 8'h30},
                   {32'hE4E4E4E4, 16'hF800, 16'h07E0});
        send_block(12'd1, 12'd0, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0);
        send_block(12'd2, 12'd0, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0);
        send_block(12'd0, 12'd2, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0);
        send_block(12'd0, 12'd1, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0);

        // A zero dimension leaves no texel inside the mip.
        set_mip(15'd0, 15'd16384);
        send_block(12'd0, 12'd0, '1, '1);
        set_mip(15'd16384, 15'd0);
        send_block(12'd0, 12'd0, '1, '1);

        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 40);
                end
                2: begin
                    w = $urandom_range(1, 700);
                    h = $urandom_range(1, 700);
                end
                default: begin
                    w = $urandom_range(1, 16384);
                    h = $urandom_range(1, 16384);
                end
            endcase
            set_mip(15'(w), 15'(h));
            sender_idles   = 1'($urandom_range(0, 1));
            receiver_idles = 1'($urandom_range(0, 1));
            for (n = 0; n < 33; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    col = 12'($urandom_range(0, 4095));
                    row = 12'($urandom_range(0, 4095));
                end else begin
                    col = 12'($urandom_range(0, (w + 3) / 4 < 4095 ? (w + 3) / 4 : 4095));
                    row = 12'($urandom_range(0, (h + 3) / 4 < 4095 ? (h + 3) / 4 : 4095));
                end
                send_block(col, row, {$urandom, $urandom}, {$urandom, $urandom});
            end
        end

        drain();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
